>>> sv/fir_pkg.sv
`default_nettype none

package fir_pkg;

  // Fixed field and register widths
  localparam int OUT_BITS       = 36;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int TAP_COUNT_W    = 5;
  localparam int COEFF_WORDS    = 4;
  localparam int SLOTS_PER_WORD = 4;
  localparam int SLOT_BITS      = 16;
  localparam int COEFF_SLOTS    = COEFF_WORDS * SLOTS_PER_WORD;

  // Parameter defaults
  localparam int DEF_MAX_TAPS    = 16;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COEFF_BITS  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_3   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUSH
  } fir_state_t;

endpackage

`default_nettype wire

>>> sv/fir_filter_same_mode_unit.sv
// Flow: for each result, taps from its zero-padding shift d (0 for ordinary results) up
//   to the last are issued in ST_ISSUE, ST_DRAIN empties the pipeline, and ST_PUSH loads
//   the output register, waiting on out_stall; the first starts in the cycle after the
//   sample beat is accepted. in_stall holds off a new sample until the last result of the
//   current one is pushed; a sample that releases no result leaves the unit in ST_IDLE.
// Reset (rst_n low, synchronous): tap count 1, coefficients zero, delay line empty.
`default_nettype none

module fir_filter_same_mode_unit
  import fir_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COEFF_BITS  = DEF_COEFF_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // sample channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [SAMPLE_BITS-1:0] in_sample,
  input  wire                          in_block_end,
  // result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [OUT_BITS-1:0]   out_filtered,
  output logic                         out_run_last,
  // configuration write port
  input  wire                          cfg_we,
  input  wire [CFG_IDX_W-1:0]          cfg_index,
  input  wire [CFG_DATA_W-1:0]         cfg_wdata
);

  // KW indexes taps and memory entries; CW holds a count up to MAX_TAPS.
  localparam int KW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW       = $clog2(MAX_TAPS + 1) + 1;
  localparam int PROD_W   = SAMPLE_BITS + COEFF_BITS;
  localparam int EXT_W    = (PROD_W > OUT_BITS) ? PROD_W : OUT_BITS;
  localparam int SLOT_EXT = (COEFF_BITS > SLOT_BITS) ? COEFF_BITS : SLOT_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic [CFG_DATA_W-1:0]  coeff_word_r [COEFF_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_W'(1);
      for (int w = 0; w < COEFF_WORDS; w++) begin
        coeff_word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count_r     <= cfg_wdata[TAP_COUNT_W-1:0];
        REG_COEFF_0:   coeff_word_r[0] <= cfg_wdata;
        REG_COEFF_1:   coeff_word_r[1] <= cfg_wdata;
        REG_COEFF_2:   coeff_word_r[2] <= cfg_wdata;
        REG_COEFF_3:   coeff_word_r[3] <= cfg_wdata;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // Unpack coefficients: each 16-bit slot is read as a signed COEFF_BITS value taken
  // from its low bits. Taps past the packed slots read as zero.
  logic signed [COEFF_BITS-1:0] coef_arr [MAX_TAPS];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_coef
    if (j < COEFF_SLOTS) begin : g_slot
      localparam int WI = j / SLOTS_PER_WORD;
      localparam int SI = (j % SLOTS_PER_WORD) * SLOT_BITS;
      logic [SLOT_EXT-1:0] slot_z;
      assign slot_z      = SLOT_EXT'(coeff_word_r[WI][SI +: SLOT_BITS]);
      assign coef_arr[j] = slot_z[COEFF_BITS-1:0];
    end else begin : g_zero
      assign coef_arr[j] = '0;
    end
  end

  // Taps in use: zero counts as one, anything past the delay line as MAX_TAPS.
  logic [CW-1:0] taps_use;
  logic [KW-1:0] start_pos;

  always_comb begin
    if (tap_count_r == '0) begin
      taps_use = CW'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      taps_use = CW'(MAX_TAPS);
    end else begin
      taps_use = CW'(tap_count_r);
    end
    start_pos = KW'((taps_use - CW'(1)) >> 1);
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  fir_state_t state_r, state_nxt;

  logic [KW-1:0] wp_r;        // entry that holds the newest sample
  logic [CW-1:0] count_r;     // samples in the current block, saturating at MAX_TAPS
  logic [CW-1:0] len_r;       // samples visible to the item at work
  logic [CW-1:0] taps_r;
  logic [KW-1:0] d_r;         // padding shift of the result at work
  logic [KW-1:0] d_end_r;     // shift of the item's final result
  logic          last_r;
  logic [KW-1:0] k_r;         // tap being issued

  logic in_acc;
  logic issue_en;
  logic push_en;
  logic pipe_busy;

  // Item acceptance bookkeeping
  logic [KW-1:0] wp_nxt;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] start_c;
  logic [CW-1:0] first_c;
  logic          no_result;

  always_comb begin
    wp_nxt    = (wp_r == KW'(MAX_TAPS - 1)) ? '0 : wp_r + KW'(1);
    cnt_inc   = (count_r < CW'(MAX_TAPS)) ? count_r + CW'(1) : count_r;
    start_c   = CW'(start_pos);
    first_c   = (start_c + CW'(1) > cnt_inc) ? start_c + CW'(1) - cnt_inc : '0;
    no_result = !in_block_end && (cnt_inc <= start_c);
  end

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !no_result) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (CW'(k_r) == taps_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_en) begin
          state_nxt = (d_r == d_end_r) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    in_acc   = in_valid && (state_r == ST_IDLE);
    issue_en = (state_r == ST_ISSUE);
    push_en  = (state_r == ST_PUSH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      count_r <= '0;
      len_r   <= '0;
      taps_r  <= CW'(1);
      d_r     <= '0;
      d_end_r <= '0;
      last_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        // Advance the ring; a block end drops the whole delay line by zeroing the count.
        wp_r    <= wp_nxt;
        count_r <= in_block_end ? '0 : cnt_inc;
        len_r   <= cnt_inc;
        taps_r  <= taps_use;
        last_r  <= in_block_end;
        d_r     <= in_block_end ? KW'(first_c) : '0;
        d_end_r <= in_block_end ? start_pos : '0;
        k_r     <= in_block_end ? KW'(first_c) : '0;
      end else if (issue_en) begin
        if (state_nxt == ST_ISSUE) begin
          k_r <= k_r + KW'(1);
        end
      end else if (push_en && (d_r != d_end_r)) begin
        d_r <= d_r + KW'(1);
        k_r <= d_r + KW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Delay-line memory: ring of MAX_TAPS samples, one write and one read port.
  // The sample is written at acceptance, reads start the cycle after, so no
  // read can hit an entry whose write is still pending.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] dl_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [KW-1:0]          tap_off;
  logic [KW:0]            wrap_sum;
  logic [KW-1:0]          rd_addr;

  always_comb begin
    tap_off  = k_r - d_r;
    wrap_sum = {1'b0, wp_r} + (KW+1)'(MAX_TAPS) - {1'b0, tap_off};
    rd_addr  = (wp_r >= tap_off) ? wp_r - tap_off : wrap_sum[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_mem[wp_nxt] <= in_sample;
    end
    rdata_r <= dl_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate pipeline: read, multiply, accumulate.
  // Entries at or beyond the block's sample count are stale and count as zero.
  // ---------------------------------------------------------------------------
  logic                         s1_v_r;
  logic                         s1_ok_r;
  logic signed [COEFF_BITS-1:0] s1_coef_r;
  logic                         s2_v_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [EXT_W-1:0]      prod_ext;
  logic [OUT_BITS-1:0]          acc_r;

  assign pipe_busy = s1_v_r || s2_v_r;
  assign prod_ext  = EXT_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue_en;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r   <= (CW'(tap_off) < len_r);
    s1_coef_r <= coef_arr[k_r];
    // Keep the multiply signed on its own; drop a stale entry to zero.
    if (s1_ok_r) begin
      prod_r <= $signed(rdata_r) * s1_coef_r;
    end else begin
      prod_r <= '0;
    end
    if (in_acc || push_en) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + prod_ext[OUT_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished beat while the next item is taken in.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (push_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      out_filtered <= acc_r;
      out_run_last <= last_r && (d_r == d_end_r);
    end
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_pkg::*;

  localparam int SB            = DEF_SAMPLE_BITS;
  // Covers one result at the worst case of 16 taps; leave headroom for a stalled flush.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 6;
  localparam int PHASE_BEATS   = 26;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       run_last;
  } fir_out_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  // One row of the directed plan: a register write or a sample beat. Beats marked
  // typed carry a hand-computed result that replaces the predicted one.
  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       reg_index;
    logic [CFG_DATA_W-1:0]      value;
    logic signed [SB-1:0]       sample;
    logic                       block_end;
    logic                       typed;
    logic signed [OUT_BITS-1:0] typed_filtered;
    logic                       typed_last;
  } plan_row_t;

  localparam int PLAN_ROWS = 36;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Out of reset: one tap, zero coefficients, so every sample gives zero.
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b0, 1'b1, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b1, 1'b1, 36'sd0, 1'b1},
    // Single tap at full negative scale: products at both extremes.
    '{ROW_WRITE, REG_COEFF_0, 64'h0000_0000_0000_8000, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b1, 36'sd1073741824, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b1, 1'b1, -36'sd1073709056, 1'b1},
    // Tap count of zero acts as one; a one-sample block.
    '{ROW_WRITE, REG_TAP_COUNT, 64'd0, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'shFFFF, 1'b1, 1'b1, 36'sd32768, 1'b1},
    // Full sixteen taps, with extreme coefficients in the first three words.
    '{ROW_WRITE, REG_TAP_COUNT, 64'd16, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_WRITE, REG_COEFF_0, 64'h7FFF_8000_0001_FFFF, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_WRITE, REG_COEFF_1, 64'h8000_8000_8000_8000, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_WRITE, REG_COEFF_2, 64'h7FFF_7FFF_7FFF_7FFF, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_WRITE, REG_COEFF_3, 64'h1234_FEDC_0000_8001, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    // Block shorter than the centering offset: every result comes from the flush.
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh0000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b1, 1'b0, 36'sd0, 1'b0},
    // Nine-sample block: one streamed result, then the longest flush.
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh0001, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'shFFFF, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh7FFF, 1'b1, 1'b0, 36'sd0, 1'b0},
    // Tap count above the maximum clamps to sixteen.
    '{ROW_WRITE, REG_TAP_COUNT, 64'd31, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sh8000, 1'b1, 1'b0, 36'sd0, 1'b0},
    // Tap count changed in the middle of a block.
    '{ROW_WRITE, REG_TAP_COUNT, 64'd5, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sd1000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, -16'sd2000, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_WRITE, REG_TAP_COUNT, 64'd1, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sd3000, 1'b1, 1'b0, 36'sd0, 1'b0},
    // Even tap count: centering offset rounds down.
    '{ROW_WRITE, REG_TAP_COUNT, 64'd2, 16'sd0, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, 16'sd12345, 1'b0, 1'b0, 36'sd0, 1'b0},
    '{ROW_BEAT,  REG_TAP_COUNT, 64'd0, -16'sd12345, 1'b1, 1'b0, 36'sd0, 1'b0}
  };

  // DUT drive and observation
  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic signed [SB-1:0]       in_sample    = '0;
  logic                       in_block_end = 1'b0;
  logic                       out_stall    = 1'b0;
  logic                       cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata    = '0;
  wire                        in_stall;
  wire                        out_valid;
  wire signed [OUT_BITS-1:0]  out_filtered;
  wire                        out_run_last;

  // Predictor state: shadow registers, delay line (newest first) and fill count.
  logic [TAP_COUNT_W-1:0]     tap_reg;
  logic [CFG_DATA_W-1:0]      coeff_reg [COEFF_WORDS];
  logic signed [SB-1:0]       line_mem  [DEF_MAX_TAPS];
  int unsigned                block_fill;

  fir_out_t                   step_outputs [$];
  fir_out_t                   due_outputs  [$];
  int unsigned                mismatches = 0;

  // Sender burst shaping
  int unsigned                burst_left = 0;
  int unsigned                gap;

  // Receiver stall shaping
  int unsigned                stall_mode = 0;
  int unsigned                mode_left  = 0;
  int unsigned                stall_tick = 0;
  fir_out_t                   want;

  fir_filter_same_mode_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_run_last (out_run_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Sum over k of x[f - k] * coeff[k]; the delay line head holds x[f - shift].
  function automatic logic signed [OUT_BITS-1:0] tap_sum(input int unsigned taps,
                                                         input int unsigned shift);
    logic signed [OUT_BITS-1:0]  acc;
    logic signed [SLOT_BITS-1:0] c;
    acc = '0;
    for (int unsigned k = shift; k < taps; k++) begin
      c   = coeff_reg[k / SLOTS_PER_WORD][(k % SLOTS_PER_WORD) * SLOT_BITS +: SLOT_BITS];
      acc = acc + line_mem[k - shift] * c;
    end
    return acc;
  endfunction

  // Advance the delay line by one sample and collect the results it releases.
  function automatic void fir_predict(input logic signed [SB-1:0] s, input logic last);
    int unsigned taps;
    int unsigned center;
    int unsigned first;
    taps   = (tap_reg == 0) ? 1 : (tap_reg > DEF_MAX_TAPS) ? DEF_MAX_TAPS : tap_reg;
    center = (taps - 1) / 2;
    step_outputs.delete();
    for (int i = DEF_MAX_TAPS - 1; i > 0; i--) line_mem[i] = line_mem[i - 1];
    line_mem[0] = s;
    if (block_fill < 31) block_fill++;
    if (!last) begin
      if (block_fill > center) step_outputs.push_back('{tap_sum(taps, 0), 1'b0});
    end else begin
      // Flush: zero padding shifts the window one step per result.
      first = (center + 1 > block_fill) ? center + 1 - block_fill : 0;
      for (int unsigned d = first; d <= center; d++)
        step_outputs.push_back('{tap_sum(taps, d), d == center});
      foreach (line_mem[i]) line_mem[i] = '0;
      block_fill = 0;
    end
  endfunction

  // Offer one sample beat, hold it until taken, then maybe open a gap.
  task automatic drive_beat(input logic signed [SB-1:0] s, input logic last,
                            input logic typed, input fir_out_t typed_out);
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_block_end <= last;
    do @(posedge clk); while (in_stall);
    fir_predict(s, last);
    if (typed) due_outputs.push_back(typed_out);
    else foreach (step_outputs[i]) due_outputs.push_back(step_outputs[i]);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
      gap        = $urandom_range(1, 25);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write a register once the block has gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    // A sample that releases no result may still be in flight; let it finish.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TAP_COUNT: tap_reg      = data[TAP_COUNT_W-1:0];
      REG_COEFF_0:   coeff_reg[0] = data;
      REG_COEFF_1:   coeff_reg[1] = data;
      REG_COEFF_2:   coeff_reg[2] = data;
      REG_COEFF_3:   coeff_reg[3] = data;
      default: ;
    endcase
  endtask

  // Result side: check each taken beat, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result filtered=%0d run_last=%0b",
                                  out_filtered, out_run_last));
      end else begin
        want = due_outputs.pop_front();
        if (out_filtered !== want.filtered)
          report_mismatch($sformatf("filtered %0d, expected %0d", out_filtered,
                                    want.filtered));
        if (out_run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, expected %0b", out_run_last,
                                    want.run_last));
      end
    end
    // Rotate among free flow, light and heavy random stalls, and a fixed 2-of-3 stall.
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 3 != 0);
    endcase
  end

  initial begin
    logic signed [SB-1:0]  s;
    logic [CFG_DATA_W-1:0] word;
    int unsigned           block_left;
    int unsigned           blocks_begun;
    int unsigned           waited;

    // Shadow the reset state.
    tap_reg    = TAP_COUNT_W'(1);
    block_fill = 0;
    foreach (coeff_reg[i]) coeff_reg[i] = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    block_left   = 0;
    blocks_begun = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE)
        write_reg(PLAN[r].reg_index, PLAN[r].value);
      else
        drive_beat(PLAN[r].sample, PLAN[r].block_end, PLAN[r].typed,
                   '{PLAN[r].typed_filtered, PLAN[r].typed_last});
    end

    // Random phases. Blocks may stay open across a phase boundary, so tap count
    // changes also land inside blocks.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        // Largest magnitude sums: sixteen taps, all coefficients at one extreme.
        write_reg(REG_TAP_COUNT, 64'd16);
        word = (p == 0) ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF;
        write_reg(REG_COEFF_0, word);
        write_reg(REG_COEFF_1, word);
        write_reg(REG_COEFF_2, word);
        write_reg(REG_COEFF_3, word);
      end else begin
        write_reg(REG_TAP_COUNT,
                  CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(1, 16)));
        write_reg(REG_COEFF_0, {$urandom, $urandom});
        write_reg(REG_COEFF_1, {$urandom, $urandom});
        write_reg(REG_COEFF_2, {$urandom, $urandom});
        write_reg(REG_COEFF_3, {$urandom, $urandom});
      end
      for (int b = 0; b < PHASE_BEATS; b++) begin
        if (block_left == 0) begin
          blocks_begun++;
          // Now and then a block long enough to saturate the fill count.
          block_left = (blocks_begun % 9 == 4) ? $urandom_range(32, 40) : $urandom_range(1, 12);
        end
        block_left--;
        if (p == 0) begin
          s = 16'sh8000;
        end else begin
          case ($urandom_range(0, 7))
            0:       s = 16'sh8000;
            1:       s = 16'sh7FFF;
            2:       s = ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shFFFF;
            default: s = SB'($urandom_range(0, 16'hFFFF));
          endcase
        end
        drive_beat(s, block_left == 0, 1'b0, '0);
      end
    end

    // Drain, then give stray results a chance to show up.
    in_valid <= 1'b0;
    waited = 0;
    while (due_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_outputs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_outputs.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
